[src/blss_pkg.sv]
// shared types and constants for the binary load segment splitter
`timescale 1ns / 1ps
`default_nettype none
package blss_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_CHUNK      = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_END_BELOW  = 3'd2,
    ST_TRUNCATED  = 3'd3,
    ST_TOO_LONG   = 3'd4
  } status_t;

  // chunk kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_INIT = 2'd2
  } kind_t;

  // one result beat
  typedef struct packed {
    status_t     status;
    logic [15:0] chunk_start;
    logic [15:0] chunk_end;
    logic [15:0] chunk_length;
    logic [15:0] file_offset;
    kind_t       chunk_kind;
    logic [15:0] bank_number;
  } result_t;

  localparam logic [7:0]  MARK_BYTE   = 8'hFF;
  localparam logic [15:0] RUN_START   = 16'h02E0;
  localparam logic [15:0] RUN_END     = 16'h02E1;
  localparam logic [15:0] INIT_START  = 16'h02E2;
  localparam logic [15:0] INIT_END    = 16'h02E3;
  localparam logic [15:0] LIMIT_RESET = 16'(8192 - 32 - 6);

endpackage
`default_nettype wire

[src/blss_parser.sv]
// parser state and per-byte result logic
`timescale 1ns / 1ps
`default_nettype none
module blss_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,       // byte in the input register is consumed
  input  wire logic [7:0]       data_byte,
  input  wire logic             last_byte,
  input  wire logic [15:0]      chunk_limit,
  output      logic             produce,    // the byte in the input register gives a result
  output      blss_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_SLO   = 3'd0,
    PH_MARK2 = 3'd1,
    PH_SLO2  = 3'd2,
    PH_SHI   = 3'd3,
    PH_ELO   = 3'd4,
    PH_EHI   = 3'd5,
    PH_DATA  = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [16:0] offset_r, offset_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [15:0] seg_start_r, seg_start_nxt;
  blss_pkg::kind_t kind_r, kind_nxt;
  logic [16:0] data_left_r, data_left_nxt;
  logic [15:0] chunk_left_r, chunk_left_nxt;
  logic [15:0] next_addr_r, next_addr_nxt;
  logic [15:0] bank_r, bank_nxt;
  logic [16:0] fill_r, fill_nxt;
  logic        halt_r, halt_nxt;

  logic [15:0] lim;
  logic [15:0] len;
  logic [16:0] fill_sum;
  logic [15:0] seg_end;
  logic        emit;
  blss_pkg::status_t err;

  // effective limit and chunk length
  assign lim      = (chunk_limit == 16'd0) ? 16'd1 : chunk_limit;
  assign len      = (data_left_r < {1'b0, lim}) ? data_left_r[15:0] : lim;
  assign fill_sum = fill_r + {1'b0, len};
  assign seg_end  = {data_byte, low_r};

  // next state and error detection
  always_comb begin
    phase_nxt      = phase_r;
    offset_nxt     = offset_r;
    low_nxt        = low_r;
    seg_start_nxt  = seg_start_r;
    kind_nxt       = kind_r;
    data_left_nxt  = data_left_r;
    chunk_left_nxt = chunk_left_r;
    next_addr_nxt  = next_addr_r;
    bank_nxt       = bank_r;
    fill_nxt       = fill_r;
    halt_nxt       = halt_r;
    err            = blss_pkg::ST_CHUNK;
    emit           = 1'b0;
    if (!halt_r) begin
      if (offset_r[16]) begin
        err = blss_pkg::ST_TOO_LONG;
      end else begin
        offset_nxt = offset_r + 17'd1;
        case (phase_r)
          PH_SLO: begin
            if (data_byte == blss_pkg::MARK_BYTE) begin
              low_nxt   = data_byte;
              phase_nxt = PH_MARK2;
            end else if (offset_r == 17'd0) begin
              err = blss_pkg::ST_BAD_HEADER;
            end else begin
              low_nxt   = data_byte;
              phase_nxt = PH_SHI;
            end
          end
          PH_MARK2: begin
            if (data_byte == blss_pkg::MARK_BYTE) begin
              phase_nxt = PH_SLO2;
            end else if (offset_r < 17'd2) begin
              err = blss_pkg::ST_BAD_HEADER;
            end else begin
              seg_start_nxt = {data_byte, low_r};
              phase_nxt     = PH_ELO;
            end
          end
          PH_SLO2, PH_ELO: begin
            low_nxt   = data_byte;
            phase_nxt = (phase_r == PH_SLO2) ? PH_SHI : PH_EHI;
          end
          PH_SHI: begin
            seg_start_nxt = {data_byte, low_r};
            phase_nxt     = PH_ELO;
          end
          PH_EHI: begin
            if (seg_end < seg_start_r) begin
              err = blss_pkg::ST_END_BELOW;
            end else begin
              data_left_nxt = {1'b0, seg_end} - {1'b0, seg_start_r} + 17'd1;
              if (seg_start_r == blss_pkg::RUN_START && seg_end == blss_pkg::RUN_END)
                kind_nxt = blss_pkg::KIND_RUN;
              else if (seg_start_r == blss_pkg::INIT_START && seg_end == blss_pkg::INIT_END)
                kind_nxt = blss_pkg::KIND_INIT;
              else
                kind_nxt = blss_pkg::KIND_DATA;
              next_addr_nxt  = seg_start_r;
              chunk_left_nxt = 16'd0;
              phase_nxt      = PH_DATA;
            end
          end
          PH_DATA: begin
            // new chunk opens on this byte
            if (chunk_left_r == 16'd0) begin
              emit           = 1'b1;
              chunk_left_nxt = len - 16'd1;
              next_addr_nxt  = next_addr_r + len;
              if (fill_sum >= {1'b0, lim}) begin
                fill_nxt = 17'd0;
                bank_nxt = bank_r + 16'd1;
              end else begin
                fill_nxt = fill_sum;
              end
            end else begin
              chunk_left_nxt = chunk_left_r - 16'd1;
            end
            if (data_left_r != 17'd0) begin
              data_left_nxt = data_left_r - 17'd1;
            end
            if (data_left_r <= 17'd1) begin
              phase_nxt = PH_SLO;
            end
          end
          default: begin
            phase_nxt = PH_SLO;
          end
        endcase
      end
      // end of file checks
      if (err == blss_pkg::ST_CHUNK && last_byte) begin
        if (offset_r == 17'd0)
          err = blss_pkg::ST_BAD_HEADER;
        else if (phase_nxt != PH_SLO)
          err = blss_pkg::ST_TRUNCATED;
      end
      if (err != blss_pkg::ST_CHUNK) begin
        halt_nxt = 1'b1;
      end
    end
    // last byte returns the parser to its reset state
    if (last_byte) begin
      phase_nxt      = PH_SLO;
      offset_nxt     = 17'd0;
      low_nxt        = 8'd0;
      seg_start_nxt  = 16'd0;
      kind_nxt       = blss_pkg::KIND_DATA;
      data_left_nxt  = 17'd0;
      chunk_left_nxt = 16'd0;
      next_addr_nxt  = 16'd0;
      bank_nxt       = 16'd0;
      fill_nxt       = 17'd0;
      halt_nxt       = 1'b0;
    end
  end

  // result beat
  always_comb begin
    produce = emit || (err != blss_pkg::ST_CHUNK);
    if (err != blss_pkg::ST_CHUNK) begin
      res        = '0;
      res.status = err;
    end else begin
      res.status       = blss_pkg::ST_CHUNK;
      res.chunk_start  = next_addr_r;
      res.chunk_end    = next_addr_r + len - 16'd1;
      res.chunk_length = len;
      res.file_offset  = offset_r[15:0];
      res.chunk_kind   = kind_r;
      res.bank_number  = bank_r;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SLO;
      offset_r     <= 17'd0;
      low_r        <= 8'd0;
      seg_start_r  <= 16'd0;
      kind_r       <= blss_pkg::KIND_DATA;
      data_left_r  <= 17'd0;
      chunk_left_r <= 16'd0;
      next_addr_r  <= 16'd0;
      bank_r       <= 16'd0;
      fill_r       <= 17'd0;
      halt_r       <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      offset_r     <= offset_nxt;
      low_r        <= low_nxt;
      seg_start_r  <= seg_start_nxt;
      kind_r       <= kind_nxt;
      data_left_r  <= data_left_nxt;
      chunk_left_r <= chunk_left_nxt;
      next_addr_r  <= next_addr_nxt;
      bank_r       <= bank_nxt;
      fill_r       <= fill_nxt;
      halt_r       <= halt_nxt;
    end
  end

`ifndef SYNTH
  // halted parser stays silent
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> !produce)
    else $error("result while halted");

  // data phase always has bytes left
  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (data_left_r != 17'd0))
    else $error("data phase with nothing left");

  // chunk never outruns its segment
  a_chunk_in_seg: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, chunk_left_r} <= data_left_r)
    else $error("chunk longer than segment remainder");

  // last byte restarts the parser
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && last_byte) |=> (phase_r == PH_SLO && offset_r == 17'd0 && !halt_r))
    else $error("parser not cleared after last byte");
`endif

endmodule
`default_nettype wire

[src/blss_out_reg.sv]
// result register on the master side
`timescale 1ns / 1ps
`default_nettype none
module blss_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire blss_pkg::result_t res,
  input  wire logic              out_tready,
  output      logic              out_tvalid,
  output      logic              free,
  output      blss_pkg::result_t res_q
);

  logic              valid_r, valid_nxt;
  blss_pkg::result_t data_r;

  // register can take a new beat when empty or draining
  assign free       = !valid_r || out_tready;
  assign valid_nxt  = load || (valid_r && !out_tready);
  assign out_tvalid = valid_r;
  assign res_q      = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

`ifndef SYNTH
  // loads only happen into a free register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("result register overwritten");

  // a loaded beat shows up next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_tvalid)
    else $error("loaded beat not presented");

  // stalled beat is not replaced
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(data_r))
    else $error("stalled beat changed");
`endif

endmodule
`default_nettype wire

[src/binary_load_segment_splitter_unit.sv]
// top level: binary load file segment splitter
//
//  channel | direction | payload
//  in_     | slave     | tdata[7:0] data_byte, tlast last_byte
//  out_    | master    | tdata start/end/length/offset/bank, tuser status/kind
//  cfg_    | slave     | cfg_data[15:0] chunk_limit, always ready
//
//  one byte per cycle unless a result waits on a stalled result register; results go input register to result register
//  all parsing for a byte is done in the cycle it sits in the input register
//  a byte that gives a result waits only while the result register is full and stalled
//  bytes that give no result keep flowing past a stalled result
//  reset is synchronous, active low; chunk_limit resets to 8154
`timescale 1ns / 1ps
`default_nettype none
module binary_load_segment_splitter_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] data_byte
  input  wire logic        in_tlast,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [79:0] out_tdata,   // [15:0] chunk_start, [31:16] chunk_end,
                                        // [47:32] chunk_length, [63:48] file_offset,
                                        // [79:64] bank_number
  output      logic [7:0]  out_tuser,   // [2:0] status, [4:3] chunk_kind, [7:5] zero
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic [15:0]       limit_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic [7:0]        s1_byte_r;
  logic              s1_last_r;
  logic              s1_go;
  logic              produce;
  logic              out_free;
  blss_pkg::result_t res;
  blss_pkg::result_t res_q;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= blss_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_data;
    end
  end

  // input register handshake
  assign s1_go        = s1_valid_r && (!produce || out_free);
  assign in_tready    = !s1_valid_r || s1_go;
  assign s1_valid_nxt = (in_tvalid && in_tready) || (s1_valid_r && !s1_go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  blss_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_go),
    .data_byte   (s1_byte_r),
    .last_byte   (s1_last_r),
    .chunk_limit (limit_r),
    .produce     (produce),
    .res         (res)
  );

  blss_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_go && produce),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .free       (out_free),
    .res_q      (res_q)
  );

  // pack the result beat
  assign out_tdata = {res_q.bank_number, res_q.file_offset, res_q.chunk_length,
                      res_q.chunk_end, res_q.chunk_start};
  assign out_tuser = {3'b000, res_q.chunk_kind, res_q.status};

endmodule
`default_nettype wire
